/* src/edtc_pkg.sv */
// Shared constants for the epoch date and time converter.
`default_nettype none
package edtc_pkg;

	localparam int unsigned DayW = 11;

	typedef enum logic {
		ACT_ENCODE = 1'b0,
		ACT_DECODE = 1'b1
	} action_t;

	localparam logic [15:0] DAYS_PER_CYCLE = 16'd1461;
	localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
	localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
	localparam logic [16:0] SECS_PER_MIN   = 17'd60;

	// Reciprocals: x/15 = (x*M15)>>35, x/3 = (x*M3)>>33, x/1461 = (x*M1461)>>32 (x < 2^16)
	localparam logic [31:0] M15   = 32'h8888_8889;
	localparam logic [31:0] M3    = 32'hAAAA_AAAB;
	localparam logic [21:0] M1461 = 22'd2939746;

	localparam logic [DayW-1:0] MONTH_START [4][12] = '{
		'{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
		  11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
		'{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
		  11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
		'{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
		  11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
		'{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
		  11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
	};

endpackage
`default_nettype wire

/* src/epoch_date_time_converter_unit.sv */
// Seconds count since year 0 to and from calendar date and time, seven stage pipeline.
//
//  channel | signals                                    | dir
//  --------+--------------------------------------------+-----
//  in      | in_valid, in_stall, action, seconds_in,    | in
//          | second_in .. year_in                       |
//  out     | out_valid, out_stall, seconds_out,         | out
//          | second_out .. year_out                     |
//
// One beat per cycle sustained, either direction, while out_stall does not hold a result.
// The decode chain of constant-reciprocal divides (60, 60, 24, 1461) sets the depth.
// arst_n clears the stage valid bits only.
// out_stall freezes every stage while a result is held; in_stall follows it then.
`default_nettype none
module epoch_date_time_converter_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         action,
	input  wire logic [31:0]  seconds_in,
	input  wire logic [5:0]   second_in,
	input  wire logic [5:0]   minute_in,
	input  wire logic [4:0]   hour_in,
	input  wire logic [4:0]   day_in,
	input  wire logic [3:0]   month_in,
	input  wire logic [6:0]   year_in,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [31:0]       seconds_out,
	output logic [5:0]        second_out,
	output logic [5:0]        minute_out,
	output logic [4:0]        hour_out,
	output logic [4:0]        day_out,
	output logic [3:0]        month_out,
	output logic [7:0]        year_out
);
	import edtc_pkg::*;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	action_t act_s1, act_s2, act_s3, act_s4, act_s5, act_s6, act_s7;

	// encode path
	logic [3:0]      mi;
	logic [DayW-1:0] mstart;
	logic [31:0]     days_c;
	logic [16:0]     tod_c;
	logic [31:0]     days_s1;
	logic [16:0]     tod_s1, tod_s2;
	logic [31:0]     prod_s2;
	logic [31:0]     enc_s3, enc_s4, enc_s5, enc_s6;

	// decode path
	logic [31:0] t_s1;
	logic [61:0] p1_s1;
	logic [26:0] q1_c, q1_s2;
	logic [56:0] p2_s2;
	logic [20:0] q2_c, q2_s3;
	logic [49:0] p3_s3;
	logic [15:0] q3_c, q3_s4;
	logic [37:0] p4_s4;
	logic [5:0]  cyc_c;
	logic [5:0]  sec_s2, sec_s3, sec_s4, sec_s5, sec_s6;
	logic [5:0]  min_s3, min_s4, min_s5, min_s6;
	logic [4:0]  hour_s4, hour_s5, hour_s6;
	logic [5:0]  cyc_s5, cyc_s6;
	logic [DayW-1:0] rem_s5, rem_s6;
	logic [1:0]  yi_c, yi_s6;
	logic [3:0]  mo_c;
	logic [4:0]  day_c;

	assign adv      = !(v_s7 && out_stall);
	assign in_stall = !adv;

	// stage 1 logic
	always_comb begin
		priority if (month_in == 4'd0) begin
			mi = 4'd0;
		end else if (month_in > 4'd12) begin
			mi = 4'd11;
		end else begin
			mi = month_in - 4'd1;
		end
		mstart = MONTH_START[year_in[1:0]][mi];
		days_c = 32'(year_in[6:2]) * 32'(DAYS_PER_CYCLE) + 32'(mstart) + 32'(day_in) - 32'd1;
		tod_c  = 17'(hour_in) * SECS_PER_HOUR + 17'(minute_in) * SECS_PER_MIN + 17'(second_in);
	end

	// divide chain quotients
	assign q1_c  = p1_s1[61:35];
	assign q2_c  = p2_s2[55:35];
	assign q3_c  = p3_s3[48:33];
	assign cyc_c = p4_s4[37:32];

	// year in cycle and month search
	always_comb begin
		priority if (rem_s5 >= MONTH_START[3][0]) begin
			yi_c = 2'd3;
		end else if (rem_s5 >= MONTH_START[2][0]) begin
			yi_c = 2'd2;
		end else if (rem_s5 >= MONTH_START[1][0]) begin
			yi_c = 2'd1;
		end else begin
			yi_c = 2'd0;
		end
	end

	always_comb begin
		mo_c = 4'd0;
		for (int m = 1; m < 12; m++) begin
			if (rem_s6 >= MONTH_START[yi_s6][m]) begin
				mo_c = 4'(m);
			end
		end
		day_c = 5'(rem_s6 - MONTH_START[yi_s6][mo_c] + 11'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1
			act_s1  <= action_t'(action);
			t_s1    <= seconds_in;
			p1_s1   <= 62'(seconds_in[31:2]) * 62'(M15);
			days_s1 <= days_c;
			tod_s1  <= tod_c;
			// s2
			act_s2  <= act_s1;
			q1_s2   <= q1_c;
			sec_s2  <= 6'(t_s1 - 32'(q1_c) * 32'd60);
			p2_s2   <= 57'(q1_c[26:2]) * 57'(M15);
			prod_s2 <= 32'(days_s1 * SECS_PER_DAY);
			tod_s2  <= tod_s1;
			// s3
			act_s3  <= act_s2;
			sec_s3  <= sec_s2;
			q2_s3   <= q2_c;
			min_s3  <= 6'(q1_s2 - 27'(q2_c) * 27'd60);
			p3_s3   <= 50'(q2_c[20:3]) * 50'(M3);
			enc_s3  <= prod_s2 + 32'(tod_s2);
			// s4
			act_s4  <= act_s3;
			sec_s4  <= sec_s3;
			min_s4  <= min_s3;
			q3_s4   <= q3_c;
			hour_s4 <= 5'(q2_s3 - 21'(q3_c) * 21'd24);
			p4_s4   <= 38'(q3_c) * 38'(M1461);
			enc_s4  <= enc_s3;
			// s5
			act_s5  <= act_s4;
			sec_s5  <= sec_s4;
			min_s5  <= min_s4;
			hour_s5 <= hour_s4;
			cyc_s5  <= cyc_c;
			rem_s5  <= DayW'(q3_s4 - 16'(cyc_c) * DAYS_PER_CYCLE);
			enc_s5  <= enc_s4;
			// s6
			act_s6  <= act_s5;
			sec_s6  <= sec_s5;
			min_s6  <= min_s5;
			hour_s6 <= hour_s5;
			cyc_s6  <= cyc_s5;
			yi_s6   <= yi_c;
			rem_s6  <= rem_s5;
			enc_s6  <= enc_s5;
			// s7: output register, unused fields zeroed
			act_s7 <= act_s6;
			if (act_s6 == ACT_DECODE) begin
				seconds_out <= 32'd0;
				second_out  <= sec_s6;
				minute_out  <= min_s6;
				hour_out    <= hour_s6;
				day_out     <= day_c;
				month_out   <= mo_c + 4'd1;
				year_out    <= {cyc_s6, 2'b00} + 8'(yi_s6);
			end else begin
				seconds_out <= enc_s6;
				second_out  <= 6'd0;
				minute_out  <= 6'd0;
				hour_out    <= 5'd0;
				day_out     <= 5'd0;
				month_out   <= 4'd0;
				year_out    <= 8'd0;
			end
		end
	end

	assign out_valid = v_s7;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted beat did not enter stage 1");

	a_encode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && act_s7 == ACT_ENCODE |-> second_out == 6'd0 && minute_out == 6'd0 &&
		hour_out == 5'd0 && day_out == 5'd0 && month_out == 4'd0 && year_out == 8'd0)
		else $error("encode result carries date fields");

	a_decode_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && act_s7 == ACT_DECODE |-> seconds_out == 32'd0 && second_out < 6'd60 &&
		minute_out < 6'd60 && hour_out < 5'd24 && month_out >= 4'd1 && month_out <= 4'd12 &&
		day_out >= 5'd1 && year_out <= 8'd136)
		else $error("decode result out of range");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && in_stall |=> v_s6 && $stable(rem_s6) && $stable(yi_s6))
		else $error("stage 6 moved under stall");

endmodule
`default_nettype wire

/* tb/sv/epoch_date_time_converter_unit_tb.sv */
// Testbench for the epoch date and time converter: directed table, random beats, scoreboard.
module epoch_date_time_converter_unit_tb;
	import edtc_pkg::*;

	localparam int unsigned MIN_SECS = 60;
	localparam int unsigned HOUR_MINS = 60;
	localparam int unsigned DAY_HOURS = 24;
	localparam int unsigned CYCLE_DAYS = 1461;
	localparam int unsigned DAY_SECS = 86400;
	localparam int unsigned IDLE_PCT = 22;
	localparam int RANDOM_BEATS = 630;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PRINT_CAP = 200;
	localparam int DIRECTED_ROWS = 22;

	// day offset of each month start within a four-year cycle, leap year first
	localparam int unsigned CYCLE_MONTH_DAY [48] = '{
		0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335,
		366, 397, 425, 456, 486, 517, 547, 578, 609, 639, 670, 700,
		731, 762, 790, 821, 851, 882, 912, 943, 974, 1004, 1035, 1065,
		1096, 1127, 1155, 1186, 1216, 1247, 1277, 1308, 1339, 1369, 1400, 1430
	};

	typedef struct packed {
		action_t     act;
		logic [31:0] seconds;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [6:0]  year;
	} conv_req_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [7:0]  year;
	} conv_res_t;

	typedef struct packed {
		conv_req_t req;
		logic      typed;
		conv_res_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic [31:0] seconds_in = '0;
	logic [5:0] second_in = '0;
	logic [5:0] minute_in = '0;
	logic [4:0] hour_in = '0;
	logic [4:0] day_in = '0;
	logic [3:0] month_in = '0;
	logic [6:0] year_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] seconds_out;
	logic [5:0] second_out;
	logic [5:0] minute_out;
	logic [4:0] hour_out;
	logic [4:0] day_out;
	logic [3:0] month_out;
	logic [7:0] year_out;

	conv_res_t expected_conversions [$];
	dir_row_t directed_rows [DIRECTED_ROWS];
	int mismatch_count = 0;
	int result_count = 0;
	int stalled_cycles = 0;
	bit sender_steady = 1'b0;
	bit sink_steady = 1'b0;
	int sink_hold_cycles = 0;

	epoch_date_time_converter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.seconds_in(seconds_in),
		.second_in(second_in),
		.minute_in(minute_in),
		.hour_in(hour_in),
		.day_in(day_in),
		.month_in(month_in),
		.year_in(year_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.seconds_out(seconds_out),
		.second_out(second_out),
		.minute_out(minute_out),
		.hour_out(hour_out),
		.day_out(day_out),
		.month_out(month_out),
		.year_out(year_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic conv_res_t date_seconds_convert(input conv_req_t r);
		conv_res_t o;
		logic [31:0] t;
		logic [31:0] days;
		int unsigned mi;
		int unsigned yo;
		int unsigned mo;
		int unsigned d;
		int unsigned cyc;
		o = '0;
		if (r.act == ACT_ENCODE) begin
			if (r.month == 4'd0)
				mi = 0;
			else if (r.month > 4'd12)
				mi = 11;
			else
				mi = r.month - 1;
			days = 32'(r.year >> 2) * CYCLE_DAYS
				+ CYCLE_MONTH_DAY[32'(r.year[1:0]) * 12 + mi] + 32'(r.day) - 32'd1;
			o.seconds = ((days * DAY_HOURS + 32'(r.hour)) * HOUR_MINS + 32'(r.minute)) * MIN_SECS
				+ 32'(r.second);
		end else begin
			t = r.seconds;
			o.second = 6'(t % MIN_SECS);
			t = t / MIN_SECS;
			o.minute = 6'(t % HOUR_MINS);
			t = t / HOUR_MINS;
			o.hour = 5'(t % DAY_HOURS);
			t = t / DAY_HOURS;
			cyc = t / CYCLE_DAYS;
			d = t % CYCLE_DAYS;
			yo = 3;
			while (yo > 0 && d < CYCLE_MONTH_DAY[yo * 12])
				yo--;
			mo = 11;
			while (mo > 0 && d < CYCLE_MONTH_DAY[yo * 12 + mo])
				mo--;
			o.day = 5'(d - CYCLE_MONTH_DAY[yo * 12 + mo] + 1);
			o.month = 4'(mo + 1);
			o.year = 8'(cyc * 4 + yo);
		end
		return o;
	endfunction

	function automatic conv_req_t enc_req(input int s, input int m, input int h, input int d,
			input int mo, input int y, input logic [31:0] junk);
		conv_req_t r;
		r.act = ACT_ENCODE;
		r.seconds = junk;
		r.second = 6'(s);
		r.minute = 6'(m);
		r.hour = 5'(h);
		r.day = 5'(d);
		r.month = 4'(mo);
		r.year = 7'(y);
		return r;
	endfunction

	function automatic conv_req_t dec_req(input logic [31:0] t, input bit junk_ones);
		conv_req_t r;
		r = junk_ones ? '1 : '0;
		r.act = ACT_DECODE;
		r.seconds = t;
		return r;
	endfunction

	function automatic conv_res_t secs_res(input logic [31:0] v);
		conv_res_t o;
		o = '0;
		o.seconds = v;
		return o;
	endfunction

	function automatic conv_res_t date_res(input int s, input int m, input int h, input int d,
			input int mo, input int y);
		conv_res_t o;
		o = '0;
		o.second = 6'(s);
		o.minute = 6'(m);
		o.hour = 5'(h);
		o.day = 5'(d);
		o.month = 4'(mo);
		o.year = 8'(y);
		return o;
	endfunction

	function automatic conv_req_t valid_date_req();
		return enc_req($urandom_range(59), $urandom_range(59), $urandom_range(23),
			$urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(99), $urandom());
	endfunction

	function automatic conv_req_t random_req();
		conv_req_t r;
		conv_res_t enc;
		int unsigned pick;
		int unsigned cyc;
		int unsigned yo;
		int unsigned mo;
		logic [31:0] t;
		pick = $urandom_range(99);
		r.act = ACT_ENCODE;
		r.seconds = $urandom();
		r.second = 6'($urandom());
		r.minute = 6'($urandom());
		r.hour = 5'($urandom());
		r.day = 5'($urandom());
		r.month = 4'($urandom());
		r.year = 7'($urandom());
		if (pick < 45) begin
			r = valid_date_req();
		end else if (pick < 55) begin
			r.act = ACT_ENCODE;
		end else if (pick < 75) begin
			// round trip of a real date, nudged across the second boundary
			enc = date_seconds_convert(valid_date_req());
			t = enc.seconds + 32'($urandom_range(2)) - 32'd1;
			r.act = ACT_DECODE;
			r.seconds = t;
		end else if (pick < 85) begin
			r.act = ACT_DECODE;
		end else begin
			// month, year and cycle starts, or the last second before them
			cyc = $urandom_range(34);
			yo = $urandom_range(3);
			mo = $urandom_range(11);
			t = 32'((cyc * CYCLE_DAYS + CYCLE_MONTH_DAY[yo * 12 + mo]) * DAY_SECS);
			r.act = ACT_DECODE;
			r.seconds = t - 32'($urandom_range(1));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at result %0d: %s", result_count, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	task automatic send_beat(input conv_req_t r, input logic typed, input conv_res_t typed_res);
		while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		seconds_in <= r.seconds;
		second_in <= r.second;
		minute_in <= r.minute;
		hour_in <= r.hour;
		day_in <= r.day;
		month_in <= r.month;
		year_in <= r.year;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		expected_conversions.push_back(typed ? typed_res : date_seconds_convert(r));
	endtask

	task automatic wait_drained();
		while (expected_conversions.size() != 0)
			@(posedge clk);
	endtask

	// output side
	always @(posedge clk) begin
		conv_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_conversions.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = expected_conversions.pop_front();
				check_field("seconds_out", seconds_out, want.seconds);
				check_field("second_out", 32'(second_out), 32'(want.second));
				check_field("minute_out", 32'(minute_out), 32'(want.minute));
				check_field("hour_out", 32'(hour_out), 32'(want.hour));
				check_field("day_out", 32'(day_out), 32'(want.day));
				check_field("month_out", 32'(month_out), 32'(want.month));
				check_field("year_out", 32'(year_out), 32'(want.year));
			end
			result_count++;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (sink_hold_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (sink_hold_cycles) @(posedge clk);
				sink_hold_cycles = 0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !sink_steady && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles == WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		directed_rows[0] = '{enc_req(0, 0, 0, 1, 1, 0, 0), 1'b1, secs_res(32'd0)};
		directed_rows[1] = '{dec_req(32'd0, 1'b0), 1'b1, date_res(0, 0, 0, 1, 1, 0)};
		directed_rows[2] = '{dec_req(32'hFFFF_FFFF, 1'b0), 1'b1, date_res(15, 28, 6, 6, 2, 136)};
		directed_rows[3] = '{enc_req(59, 59, 23, 31, 12, 99, 0), 1'b1, secs_res(32'd3155759999)};
		// day zero lands one day before the epoch
		directed_rows[4] = '{enc_req(0, 0, 0, 0, 1, 0, 0), 1'b1, secs_res(32'd4294880896)};
		directed_rows[5] = '{enc_req(10, 20, 5, 1, 0, 5, 0), 1'b0, '0};
		directed_rows[6] = '{enc_req(10, 20, 5, 3, 13, 6, 0), 1'b0, '0};
		directed_rows[7] = '{enc_req(10, 20, 5, 3, 15, 7, 0), 1'b0, '0};
		directed_rows[8] = '{enc_req(0, 0, 0, 31, 2, 1, 0), 1'b0, '0};
		directed_rows[9] = '{enc_req(0, 0, 12, 29, 2, 0, 0), 1'b0, '0};
		directed_rows[10] = '{enc_req(63, 63, 31, 31, 15, 127, 32'hFFFF_FFFF), 1'b0, '0};
		directed_rows[11] = '{enc_req(30, 30, 12, 15, 6, 50, 32'hFFFF_FFFF), 1'b0, '0};
		directed_rows[12] = '{dec_req(32'd3155759999, 1'b1), 1'b1, date_res(59, 59, 23, 31, 12, 99)};
		directed_rows[13] = '{dec_req(32'd3155760000, 1'b0), 1'b1, date_res(0, 0, 0, 1, 1, 100)};
		directed_rows[14] = '{dec_req(32'd86399, 1'b1), 1'b1, date_res(59, 59, 23, 1, 1, 0)};
		directed_rows[15] = '{dec_req(32'd5097600, 1'b0), 1'b1, date_res(0, 0, 0, 29, 2, 0)};
		directed_rows[16] = '{dec_req(32'd31622400, 1'b0), 1'b1, date_res(0, 0, 0, 1, 1, 1)};
		directed_rows[17] = '{dec_req(32'd126144000, 1'b0), 1'b1, date_res(0, 0, 0, 31, 12, 3)};
		directed_rows[18] = '{dec_req(32'd126230400, 1'b1), 1'b1, date_res(0, 0, 0, 1, 1, 4)};
		directed_rows[19] = '{enc_req(59, 59, 23, 31, 12, 127, 0), 1'b0, '0};
		directed_rows[20] = '{dec_req(32'h8000_0000, 1'b1), 1'b0, '0};
		directed_rows[21] = '{enc_req(0, 0, 31, 1, 1, 0, 0), 1'b0, '0};

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
		in_valid <= 1'b0;
		wait_drained();

		for (int i = 0; i < RANDOM_BEATS; i++) begin
			case (i)
				150: begin
					sender_steady = 1'b1;
					sink_steady = 1'b1;
				end
				300: begin
					// sink holds off while beats keep coming, pipeline backs up
					sink_steady = 1'b0;
					sink_hold_cycles = HOLD_CYCLES;
				end
				360: sender_steady = 1'b0;
				450: begin
					in_valid <= 1'b0;
					wait_drained();
				end
				default: ;
			endcase
			send_beat(random_req(), 1'b0, '0);
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_conversions.size() != 0)
			report_mismatch("results still outstanding at end");
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
